>>> rtl/mctt_pkg.sv
// Shared types, constants and divide-by-constant smoothing helpers for the
// MIDI clock tempo tracker. No dependencies; both RTL modules import it.
`timescale 1ns / 1ps

package mctt_pkg;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned TICK_W  = 24;
	localparam int unsigned BEAT_W  = 16;
	localparam int unsigned USMS_W  = 10;

	// Operation codes carried in tuser.
	localparam logic [OP_W-1:0] OP_US_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_RX_BYTE   = 2'd1;
	localparam logic [OP_W-1:0] OP_POS_RESET = 2'd2;

	localparam logic [BYTE_W-1:0] MIDI_CLOCK_BYTE = 8'hF8;
	localparam logic [POS_W-1:0]  POS_OFF         = 8'hFF;

	localparam logic [TICK_W-1:0] TICK_AVG_RESET = 24'd20833;
	localparam logic [TICK_W-1:0] TICK_MAX       = 24'hFF_FFFF;
	localparam logic [BEAT_W-1:0] BEAT_AVG_RESET = 16'd500;
	localparam logic [BEAT_W-1:0] MS_MAX         = 16'hFFFF;
	localparam logic [BEAT_W-1:0] TIMEOUT_RESET  = 16'd1000;
	localparam logic [USMS_W-1:0] US_LAST        = 10'd999;

	// (old*99 + new)/100 is rewritten as old + floor((new - old)/100). The
	// signed difference is biased by 100*K to stay positive, divided by an
	// exact reciprocal multiply, and K is taken back out.
	localparam logic [25:0] TICK_BIAS  = 26'd16777300;
	localparam logic [24:0] TICK_K     = 25'd167773;
	localparam logic [26:0] TICK_RECIP = 27'd85899346;

	// Same scheme for (old*19 + new)/20.
	localparam logic [17:0] BEAT_BIAS  = 18'd65540;
	localparam logic [16:0] BEAT_K     = 17'd3277;
	localparam logic [18:0] BEAT_RECIP = 19'd419431;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [TICK_W-1:0] tick_avg;
		logic [BEAT_W-1:0] beat_avg;
		logic [TICK_W-1:0] us_since_tick;
		logic [BEAT_W-1:0] ms_since_beat;
		logic [USMS_W-1:0] us_within_ms;
		logic [BEAT_W-1:0] ms_since_clock;
		logic              tick_started;
		logic              beat_started;
	} mctt_state_t;

	function automatic logic [TICK_W-1:0] smooth_tick(input logic [TICK_W-1:0] avg,
			input logic [TICK_W-1:0] delta);
		logic [25:0] biased;
		logic [52:0] prod;
		logic [24:0] sum;
		biased = {2'b00, delta} + TICK_BIAS - {2'b00, avg};
		prod   = 53'(biased) * 53'(TICK_RECIP);
		sum    = {1'b0, avg} + {5'b0, prod[52:33]} - TICK_K;
		return sum[TICK_W-1:0];
	endfunction

	function automatic logic [BEAT_W-1:0] smooth_beat(input logic [BEAT_W-1:0] avg,
			input logic [BEAT_W-1:0] delta);
		logic [17:0] biased;
		logic [36:0] prod;
		logic [16:0] sum;
		biased = {2'b00, delta} + BEAT_BIAS - {2'b00, avg};
		prod   = 37'(biased) * 37'(BEAT_RECIP);
		sum    = {1'b0, avg} + {3'b0, prod[36:23]} - BEAT_K;
		return sum[BEAT_W-1:0];
	endfunction

endpackage

>>> rtl/mctt_update.sv
// Next-state logic of the tempo tracker: timekeeping, beat position, timeout
// and both smoothing filters for one beat. Depends on mctt_pkg.
`timescale 1ns / 1ps

module mctt_update #(
	parameter int CLOCKS_PER_BEAT = 24
) (
	input  mctt_pkg::mctt_state_t              cur,
	input  logic [mctt_pkg::OP_W-1:0]          operation,
	input  logic [mctt_pkg::BYTE_W-1:0]        rx_byte,
	input  logic [mctt_pkg::BEAT_W-1:0]        timeout_ms,
	output mctt_pkg::mctt_state_t              nxt,
	output logic                               clock_seen
);
	import mctt_pkg::*;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(CLOCKS_PER_BEAT - 1);
	localparam logic [POS_W-1:0] POS_WRAP = POS_W'(256 % CLOCKS_PER_BEAT);

	logic              ms_wrap;
	logic [BEAT_W-1:0] ms_clock_adv;
	logic [POS_W-1:0]  pos_inc;
	logic [TICK_W-1:0] tick_delta;
	logic [BEAT_W-1:0] beat_delta;
	logic [TICK_W-1:0] tick_smoothed;
	logic [BEAT_W-1:0] beat_smoothed;

	always_comb begin
		ms_wrap      = (cur.us_within_ms == US_LAST);
		ms_clock_adv = (ms_wrap && cur.ms_since_clock != MS_MAX) ?
			cur.ms_since_clock + 1'b1 : cur.ms_since_clock;

		// Position only ever holds 0..CLOCKS_PER_BEAT-1 or the off-clock mark.
		if (cur.position == POS_OFF) begin
			pos_inc = POS_WRAP;
		end else if (cur.position == POS_LAST) begin
			pos_inc = '0;
		end else begin
			pos_inc = cur.position + 1'b1;
		end

		tick_delta    = cur.tick_started ? cur.us_since_tick : '0;
		beat_delta    = cur.beat_started ? cur.ms_since_beat : '0;
		tick_smoothed = smooth_tick(cur.tick_avg, tick_delta);
		beat_smoothed = smooth_beat(cur.beat_avg, beat_delta);
	end

	always_comb begin
		nxt        = cur;
		clock_seen = 1'b0;
		case (operation)
			OP_US_TICK: begin
				if (cur.us_since_tick != TICK_MAX) begin
					nxt.us_since_tick = cur.us_since_tick + 1'b1;
				end
				nxt.us_within_ms = ms_wrap ? '0 : cur.us_within_ms + 1'b1;
				if (ms_wrap && cur.ms_since_beat != MS_MAX) begin
					nxt.ms_since_beat = cur.ms_since_beat + 1'b1;
				end
				nxt.ms_since_clock = ms_clock_adv;
				if (ms_clock_adv >= timeout_ms) begin
					nxt.position       = POS_OFF;
					nxt.ms_since_clock = '0;
				end
			end
			OP_RX_BYTE: begin
				if (rx_byte == MIDI_CLOCK_BYTE) begin
					clock_seen         = 1'b1;
					nxt.position       = pos_inc;
					nxt.ms_since_clock = '0;
					nxt.us_since_tick  = '0;
					nxt.tick_started   = 1'b1;
					nxt.tick_avg       = tick_smoothed;
					if (pos_inc == '0) begin
						nxt.beat_started  = 1'b1;
						nxt.ms_since_beat = '0;
						nxt.beat_avg      = beat_smoothed;
					end
				end else if (cur.ms_since_clock >= timeout_ms) begin
					nxt.position       = POS_OFF;
					nxt.ms_since_clock = '0;
				end
			end
			OP_POS_RESET: begin
				nxt.position = '0;
			end
			default: begin
				if (cur.ms_since_clock >= timeout_ms) begin
					nxt.position       = POS_OFF;
					nxt.ms_since_clock = '0;
				end
			end
		endcase
	end

endmodule

>>> rtl/midi_clock_tempo_tracker.sv
// Top level of the MIDI clock tempo tracker: stream ports, configuration
// register, state and result registers. Depends on mctt_pkg and mctt_update.
//
//   Channel   Direction  Handshake          Payload
//   s_*       in         s_tvalid/s_tready  tuser: operation, tdata: rx_byte
//   m_*       out        m_tvalid/m_tready  tuser: clock_seen, tdata: position,
//                                           tick length (us), beat length (ms)
//   cfg_*     in         cfg_we             cfg_wdata: timeout_ms
//
// Every beat is accepted, its state update is computed by one pass through
// the update logic, and its result appears on the master side on the next
// cycle. The longest path is the reciprocal multiply of the tick smoothing
// filter. Back-to-back beats are accepted as long as the result register
// is empty or being drained in the same cycle. When m_tready is low with a
// result pending, s_tready drops and the state holds. Reset restores the
// idle state, the default tempo estimates and a timeout of 1000 ms.
`timescale 1ns / 1ps

module midi_clock_tempo_tracker #(
	parameter int CLOCKS_PER_BEAT = 24
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] operation

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] beat_position, [31:8] tick_length_us,
	                               // [47:32] beat_length_ms
	output logic        m_tuser,   // [0] clock_seen

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata  // timeout_ms
);
	import mctt_pkg::*;

	mctt_state_t       state_q;
	mctt_state_t       state_d;
	logic [BEAT_W-1:0] timeout_q;
	logic              seen_d;
	logic              s_accept;

	// The result register frees up in the same cycle it is drained, so the
	// input side keeps flowing at one beat per cycle while m_tready is high.
	assign s_tready = !m_tvalid || m_tready;
	assign s_accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	mctt_update #(
		.CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
	) u_update (
		.cur        (state_q),
		.operation  (s_tuser),
		.rx_byte    (s_tdata),
		.timeout_ms (timeout_q),
		.nxt        (state_d),
		.clock_seen (seen_d)
	);

	// Tracker state: position starts off the clock, filters at their defaults.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.position       <= POS_OFF;
			state_q.tick_avg       <= TICK_AVG_RESET;
			state_q.beat_avg       <= BEAT_AVG_RESET;
			state_q.us_since_tick  <= '0;
			state_q.ms_since_beat  <= '0;
			state_q.us_within_ms   <= '0;
			state_q.ms_since_clock <= '0;
			state_q.tick_started   <= 1'b0;
			state_q.beat_started   <= 1'b0;
		end else if (s_accept) begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	// Result payload: the state after this beat plus the clock flag.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_tdata <= {state_d.beat_avg, state_d.tick_avg, state_d.position};
			m_tuser <= seen_d;
		end
	end

endmodule

>>> rtl/mctt_checker.sv
// Port-level assertions for the MIDI clock tempo tracker, bound to the top
// level below. Depends only on the top level's port list.
`timescale 1ns / 1ps

module mctt_checker #(
	parameter int CLOCKS_PER_BEAT = 24
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The block never blocks input while its result register is empty.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// A clock beat always leaves the tracker on the clock.
	a_clock_on_grid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] < 8'(CLOCKS_PER_BEAT))
		else $error("clock beat left an invalid position");

	// Position is either inside the beat or the off-clock mark.
	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:0] < 8'(CLOCKS_PER_BEAT) || m_tdata[7:0] == 8'hFF)
		else $error("position out of range");

endmodule

bind midi_clock_tempo_tracker mctt_checker #(
	.CLOCKS_PER_BEAT (CLOCKS_PER_BEAT)
) u_mctt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
